/* rtl/bprq_pkg.sv */
// Shared types and constants for the button press/release qualifier.
// No dependencies; every other file depends on this package.
package bprq_pkg;

   localparam int unsigned MV_W    = 12;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned RUN_W   = 16;
   localparam int unsigned VIOL_W  = 8;
   localparam int unsigned STAT_W  = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // register reset values
   localparam logic [RUN_W-1:0]  COUNT_TARGET_RST    = 16'd5;
   localparam logic [TIME_W-1:0] PRESS_TIMEOUT_RST   = 32'd5000000;
   localparam logic [TIME_W-1:0] RELEASE_TIMEOUT_RST = 32'd3500000;
   localparam logic [MV_W-1:0]   IDLE_THRESH_RST     = 12'd2240;
   localparam logic [VIOL_W-1:0] VIOL_LIMIT_RST      = 8'd3;

   localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
   localparam logic [VIOL_W-1:0] VIOL_MAX = '1;

   // item opcodes
   localparam logic OP_START  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUNT_TARGET    = 3'd0,
      CSR_PRESS_TIMEOUT   = 3'd1,
      CSR_RELEASE_TIMEOUT = 3'd2,
      CSR_IDLE_THRESH     = 3'd3,
      CSR_VIOL_LIMIT      = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PRESS   = 2'd1,
      PH_RELEASE = 2'd2
   } phase_type;

   typedef enum logic [STAT_W-1:0] {
      ST_IDLE            = 3'd0,
      ST_WAIT_PRESS      = 3'd1,
      ST_PRESS_DONE      = 3'd2,
      ST_PASS            = 3'd3,
      ST_PRESS_TIMEOUT   = 3'd4,
      ST_RELEASE_TIMEOUT = 3'd5,
      ST_THRESH_ERR      = 3'd6
   } status_type;

   typedef struct packed {
      logic [RUN_W-1:0]  count_target;
      logic [TIME_W-1:0] press_timeout_us;
      logic [TIME_W-1:0] release_timeout_us;
      logic [MV_W-1:0]   idle_floor_mv;
      logic [VIOL_W-1:0] violation_limit;
   } cfg_type;

   typedef struct packed {
      logic              op;
      logic              pressed;
      logic [MV_W-1:0]   btn_mv;
      logic [TIME_W-1:0] now_us;
   } item_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [RUN_W-1:0]  press_count;
      logic [RUN_W-1:0]  release_count;
      logic [VIOL_W-1:0] violations;
   } result_type;

endpackage

/* rtl/bprq_req_if.sv */
// Request channel interface: valid/ready plus one sample or start beat.
// Depends on bprq_pkg for field widths.
interface bprq_req_if;
   logic                            valid;
   logic                            ready;
   logic                            op;
   logic                            pressed;
   logic [bprq_pkg::MV_W-1:0]       btn_mv;
   logic [bprq_pkg::TIME_W-1:0]     now_us;

   modport source (output valid, output op, output pressed, output btn_mv,
                   output now_us, input ready);
   modport sink   (input valid, input op, input pressed, input btn_mv,
                   input now_us, output ready);
endinterface

/* rtl/bprq_rsp_if.sv */
// Response channel interface: valid/ready plus one result beat.
// Depends on bprq_pkg for field widths.
interface bprq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bprq_pkg::STAT_W-1:0]     status;
   logic [bprq_pkg::RUN_W-1:0]      press_count;
   logic [bprq_pkg::RUN_W-1:0]      release_count;
   logic [bprq_pkg::VIOL_W-1:0]     violations;

   modport source (output valid, output status, output press_count,
                   output release_count, output violations, input ready);
   modport sink   (input valid, input status, input press_count,
                   input release_count, input violations, output ready);
endinterface

/* rtl/bprq_csr.sv */
// Configuration register bank, written through a plain index/data port.
// Depends on bprq_pkg.
module bprq_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bprq_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [bprq_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output bprq_pkg::cfg_type                 cfg
);
   import bprq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_idx))
            CSR_COUNT_TARGET:    cfg_in.count_target       = csr_wdata[RUN_W-1:0];
            CSR_PRESS_TIMEOUT:   cfg_in.press_timeout_us   = csr_wdata[TIME_W-1:0];
            CSR_RELEASE_TIMEOUT: cfg_in.release_timeout_us = csr_wdata[TIME_W-1:0];
            CSR_IDLE_THRESH:     cfg_in.idle_floor_mv      = csr_wdata[MV_W-1:0];
            CSR_VIOL_LIMIT:      cfg_in.violation_limit    = csr_wdata[VIOL_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_target       <= COUNT_TARGET_RST;
         cfg_ff.press_timeout_us   <= PRESS_TIMEOUT_RST;
         cfg_ff.release_timeout_us <= RELEASE_TIMEOUT_RST;
         cfg_ff.idle_floor_mv      <= IDLE_THRESH_RST;
         cfg_ff.violation_limit    <= VIOL_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/bprq_core.sv */
// Test state (phase, start time, run and violation counters) and the
// per-beat qualify/timeout/threshold logic. Depends on bprq_pkg.
module bprq_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  bprq_pkg::item_type    item,
   input  bprq_pkg::cfg_type     cfg,
   output bprq_pkg::result_type  result
);
   import bprq_pkg::*;

   phase_type         phase_ff,   phase_in;
   logic [TIME_W-1:0] start_ff,   start_in;
   logic [RUN_W-1:0]  press_ff,   press_in;
   logic [RUN_W-1:0]  release_ff, release_in;
   logic [VIOL_W-1:0] viol_ff,    viol_in;
   status_type        status;

   always_comb begin
      logic              in_press;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] limit;
      logic [RUN_W-1:0]  press_sat;
      logic [RUN_W-1:0]  release_sat;
      logic              low_idle;
      logic [VIOL_W-1:0] viol_inc;
      logic              thresh_err;

      in_press    = (phase_ff == PH_PRESS);
      elapsed     = item.now_us - start_ff;
      limit       = in_press ? cfg.press_timeout_us : cfg.release_timeout_us;
      press_sat   = (press_ff == RUN_MAX) ? RUN_MAX : press_ff + 1'b1;
      release_sat = (release_ff == RUN_MAX) ? RUN_MAX : release_ff + 1'b1;
      low_idle    = !item.pressed && (item.btn_mv < cfg.idle_floor_mv);
      viol_inc    = (viol_ff == VIOL_MAX) ? VIOL_MAX : viol_ff + 1'b1;
      thresh_err  = low_idle && (viol_inc >= cfg.violation_limit);

      phase_in   = phase_ff;
      start_in   = start_ff;
      press_in   = press_ff;
      release_in = release_ff;
      viol_in    = viol_ff;
      status     = ST_IDLE;

      if (item.op == OP_START) begin
         phase_in   = PH_PRESS;
         start_in   = item.now_us;
         press_in   = '0;
         release_in = '0;
         viol_in    = '0;
         status     = ST_WAIT_PRESS;
      end else if (phase_ff == PH_PRESS || phase_ff == PH_RELEASE) begin
         press_in   = item.pressed ? press_sat : '0;
         release_in = item.pressed ? '0 : release_sat;
         if (low_idle) viol_in = viol_inc;

         if (thresh_err) begin
            phase_in = PH_IDLE;
            status   = ST_THRESH_ERR;
         end else if (elapsed > limit) begin
            phase_in = PH_IDLE;
            status   = in_press ? ST_PRESS_TIMEOUT : ST_RELEASE_TIMEOUT;
         end else if (in_press) begin
            if (press_in >= cfg.count_target) begin
               phase_in   = PH_RELEASE;
               start_in   = item.now_us;
               release_in = '0;
               viol_in    = '0;
               status     = ST_PRESS_DONE;
            end else begin
               status = ST_WAIT_PRESS;
            end
         end else begin
            if (release_in >= cfg.count_target) begin
               phase_in = PH_IDLE;
               status   = ST_PASS;
            end else begin
               status = ST_PRESS_DONE;
            end
         end
      end else begin
         // sample while idle: no state change
         phase_in = PH_IDLE;
         status   = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         start_ff   <= '0;
         press_ff   <= '0;
         release_ff <= '0;
         viol_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         start_ff   <= start_in;
         press_ff   <= press_in;
         release_ff <= release_in;
         viol_ff    <= viol_in;
      end
   end

   assign result.status        = status;
   assign result.press_count   = press_in;
   assign result.release_count = release_in;
   assign result.violations    = viol_in;

endmodule

/* rtl/button_press_release_qualifier.sv */
// Top level of the button press/release qualifier: input stage, core, result register.
// Depends on bprq_pkg, bprq_req_if, bprq_rsp_if, bprq_csr and bprq_core.
//
//   port      dir  role
//   req_ch    in   start (op 0) or sample (op 1) beats: pressed, btn_mv, now_us
//   rsp_ch    out  one result beat per request: status and the three counters
//   csr_*     in   register writes: csr_we, csr_idx, csr_wdata
//
// Each request beat gives exactly one response beat on rsp_ch after passing
// the input register, then the result register. A beat is taken every cycle
// unless rsp_ch stalls; the state update is a single step between the two.
// Reset is synchronous, active high: phase goes idle, counters clear and
// registers return to their defaults. A stall on rsp_ch holds the result
// register and, once the input stage is also full, drops req_ch ready.
module button_press_release_qualifier (
   input  logic                             clock,
   input  logic                             reset,
   bprq_req_if.sink                         req_ch,
   bprq_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [bprq_pkg::CSR_IDX_W-1:0]   csr_idx,
   input  logic [bprq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bprq_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_vld_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_vld_ff;
   logic       stage_adv;   // input stage moves into the result register
   logic       req_take;

   bprq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // result register free or draining this cycle
   assign stage_adv    = item_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !item_vld_ff || stage_adv;
   assign req_take     = req_ch.valid && req_ch.ready;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         item_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.op      <= req_ch.op;
         item_ff.pressed <= req_ch.pressed;
         item_ff.btn_mv  <= req_ch.btn_mv;
         item_ff.now_us  <= req_ch.now_us;
      end
   end

   // state advances only when the beat moves on to the result register
   bprq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (stage_adv),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (stage_adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.status        = rsp_ff.status;
   assign rsp_ch.press_count   = rsp_ff.press_count;
   assign rsp_ch.release_count = rsp_ff.release_count;
   assign rsp_ch.violations    = rsp_ff.violations;

endmodule
